>>> hdl/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared widths, constants and types for the multi-button debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

  // Pins per expander port and derived button numbering
  localparam int PORT_WIDTH  = 8;
  localparam int BTN_COUNT   = 2 * PORT_WIDTH + 1;
  localparam int START_INDEX = 2 * PORT_WIDTH;
  localparam int IDX_W       = $clog2(BTN_COUNT);

  // Field widths
  localparam int PORT_W  = 8;
  localparam int TIME_W  = 32;
  localparam int DEB_W   = 16;

  // Packed stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;

  // Event queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One sample's worth of events: which buttons fire and their new levels
  typedef struct packed {
    logic [BTN_COUNT-1:0] mask;
    logic [BTN_COUNT-1:0] level;
  } evt_entry_t;

endpackage

>>> hdl/multi_button_debouncer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debouncer_core
// Debouncer for a start pin and two expander ports, fed by timed poll samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   carries one poll request per sample: both port levels, the start
//          pin level and a millisecond timestamp. All 17 buttons are judged
//          in the cycle the sample is taken, so a sample can enter every
//          clock while the event queue (two samples deep) has room.
//   out_*  carries one request per debounced state change, start button
//          first, then buttons 0 to 15; tlast marks the last event of a
//          sample. A sample without events produces nothing on out_*.
//   cfg_*  writes the debounce time in ms (reset value 50); write it only
//          while no events are pending.
// Flow: the first event of a sample is offered after the queue write and then
//   the output register. The output side moves one event per cycle while the
//   receiver accepts, so a sample with k events (at most 17) takes k transfers;
//   the serialiser picks one event per transfer.
// Reset clears all button state to released and empties the queue. When the
//   receiver stalls, the output register holds, the queue fills and in_tready
//   drops once two further samples with events are waiting.
// ----------------------------------------------------------------------------
module multi_button_debouncer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // port_a [7:0], port_b [15:8], start_level [16], time_ms [48:17]
  input  logic [mbd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // button_index [4:0], pressed [5]
  output logic [mbd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [mbd_pkg::DEB_W-1:0]      cfg_wr_data
);
  import mbd_pkg::*;

  logic             smp_accept;
  logic             push;
  evt_entry_t       push_entry;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  evt_entry_t       head_entry;
  logic [IDX_W-1:0] out_index;
  logic             out_pressed;

  assign in_tready  = !q_full;
  assign smp_accept = in_tvalid && in_tready;

  // Classifier with button state
  mbd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .smp_accept  (smp_accept),
    .port_a      (in_tdata[PORT_W-1:0]),
    .port_b      (in_tdata[2*PORT_W-1:PORT_W]),
    .start_level (in_tdata[2*PORT_W]),
    .time_ms     (in_tdata[2*PORT_W+TIME_W:2*PORT_W+1]),
    .push        (push),
    .push_entry  (push_entry)
  );

  // Event set queue
  mbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Event serialiser
  mbd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_index   (out_index),
    .out_pressed (out_pressed),
    .out_last    (out_tlast)
  );

  assign out_tdata = {(OUT_DATA_W - IDX_W - 1)'(0), out_pressed, out_index};

endmodule

>>> hdl/mbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_front
// Holds per-button debounce state, classifies one accepted sample per cycle
// and produces the event set for that sample.
// ----------------------------------------------------------------------------
module mbd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [mbd_pkg::DEB_W-1:0] cfg_wr_data,
  input  logic                      smp_accept,
  input  logic [mbd_pkg::PORT_W-1:0] port_a,
  input  logic [mbd_pkg::PORT_W-1:0] port_b,
  input  logic                      start_level,
  input  logic [mbd_pkg::TIME_W-1:0] time_ms,
  output logic                      push,
  output mbd_pkg::evt_entry_t       push_entry
);
  import mbd_pkg::*;

  logic [DEB_W-1:0]     debounce_ms_r;
  logic [BTN_COUNT-1:0] raw_seen_r;
  logic [BTN_COUNT-1:0] stable_r;
  logic [TIME_W-1:0]    change_time_r [BTN_COUNT];

  logic [BTN_COUNT-1:0] pressed_vec;
  logic [BTN_COUNT-1:0] raw_chg;
  logic [BTN_COUNT-1:0] evt;

  // Active-low pins to pressed bits
  always_comb begin
    pressed_vec = '0;
    pressed_vec[START_INDEX] = ~start_level;
    for (int i = 0; i < PORT_WIDTH; i++) begin
      pressed_vec[i]              = ~port_a[i];
      pressed_vec[PORT_WIDTH + i] = ~port_b[i];
    end
  end

  // Per-button classification, all buttons in parallel
  always_comb begin
    logic [TIME_W-1:0] elapsed;
    for (int i = 0; i < BTN_COUNT; i++) begin
      elapsed    = time_ms - change_time_r[i];
      raw_chg[i] = pressed_vec[i] != raw_seen_r[i];
      evt[i]     = !raw_chg[i] && (elapsed >= TIME_W'(debounce_ms_r)) &&
                   (stable_r[i] != pressed_vec[i]);
    end
  end

  assign push             = smp_accept && (|evt);
  assign push_entry.mask  = evt;
  assign push_entry.level = pressed_vec;

  // Debounce time register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEB_W'(50);
    end else if (cfg_wr_en) begin
      debounce_ms_r <= cfg_wr_data;
    end
  end

  // State update on each accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_seen_r <= '0;
      stable_r   <= '0;
      for (int i = 0; i < BTN_COUNT; i++) begin
        change_time_r[i] <= '0;
      end
    end else if (smp_accept) begin
      for (int i = 0; i < BTN_COUNT; i++) begin
        if (raw_chg[i]) begin
          raw_seen_r[i]    <= pressed_vec[i];
          change_time_r[i] <= time_ms;
        end
        if (evt[i]) begin
          stable_r[i] <= pressed_vec[i];
        end
      end
    end
  end

endmodule

>>> hdl/mbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_queue
// Short FIFO of per-sample event sets between classifier and serialiser.
// ----------------------------------------------------------------------------
module mbd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbd_pkg::evt_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output mbd_pkg::evt_entry_t head_entry
);
  import mbd_pkg::*;

  evt_entry_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hdl/mbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_back
// Serialises each event set into single events, start button first, then
// buttons 0 upwards, into a registered output stage.
// ----------------------------------------------------------------------------
module mbd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  mbd_pkg::evt_entry_t       head_entry,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mbd_pkg::IDX_W-1:0] out_index,
  output logic                      out_pressed,
  output logic                      out_last
);
  import mbd_pkg::*;

  logic [BTN_COUNT-1:0] cur_mask_r, cur_mask_nxt;
  logic [BTN_COUNT-1:0] cur_level_r, cur_level_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_index_r, out_index_nxt;
  logic                 out_pressed_r, out_pressed_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 slot_free;
  logic                 use_head;
  logic [BTN_COUNT-1:0] work_mask;
  logic [BTN_COUNT-1:0] work_level;
  logic [IDX_W-1:0]     pick_idx;
  logic [BTN_COUNT-1:0] remain;

  assign slot_free = !out_valid_r || out_ready;
  assign use_head  = (cur_mask_r == '0) && head_valid;

  // Work on the set in hand, or take the queue head when idle
  always_comb begin
    if (cur_mask_r != '0) begin
      work_mask  = cur_mask_r;
      work_level = cur_level_r;
    end else if (head_valid) begin
      work_mask  = head_entry.mask;
      work_level = head_entry.level;
    end else begin
      work_mask  = '0;
      work_level = cur_level_r;
    end
  end

  // Next event: start button wins, otherwise lowest numbered pin
  always_comb begin
    pick_idx = '0;
    for (int i = START_INDEX - 1; i >= 0; i--) begin
      if (work_mask[i]) begin
        pick_idx = IDX_W'(i);
      end
    end
    if (work_mask[START_INDEX]) begin
      pick_idx = IDX_W'(START_INDEX);
    end
    remain           = work_mask;
    remain[pick_idx] = 1'b0;
  end

  // Output stage and remaining-set update
  always_comb begin
    cur_mask_nxt    = cur_mask_r;
    cur_level_nxt   = cur_level_r;
    out_valid_nxt   = out_valid_r;
    out_index_nxt   = out_index_r;
    out_pressed_nxt = out_pressed_r;
    out_last_nxt    = out_last_r;
    pop             = 1'b0;
    if (slot_free) begin
      out_valid_nxt = work_mask != '0;
      if (work_mask != '0) begin
        out_index_nxt   = pick_idx;
        out_pressed_nxt = work_level[pick_idx];
        out_last_nxt    = remain == '0;
        cur_mask_nxt    = remain;
        cur_level_nxt   = work_level;
        pop             = use_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_mask_r  <= cur_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    cur_level_r   <= cur_level_nxt;
    out_index_r   <= out_index_nxt;
    out_pressed_r <= out_pressed_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_index   = out_index_r;
  assign out_pressed = out_pressed_r;
  assign out_last    = out_last_r;

endmodule

>>> dv/mbd_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_event_checker
// Watches the sample, event and configuration ports of the debouncer. Keeps
// its own copy of the per-button state, works out the events that each
// accepted sample should raise and compares every event request on out_*
// with the oldest one still awaited.
// ----------------------------------------------------------------------------
module mbd_event_checker
  import mbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [DEB_W-1:0]      cfg_wr_data,
  output int                    mismatch_count,
  output int                    events_pending
);

  localparam int                MAX_REPORTS    = 10;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd50;
  localparam int                TIME_LSB       = 2 * PORT_W + 1;

  typedef struct packed {
    logic [IDX_W-1:0] button;
    logic             pressed;
    logic             last;
  } btn_event_t;

  // Model state, one bit or timestamp per button (start button at the top)
  logic [DEB_W-1:0]     debounce_time;
  logic [BTN_COUNT-1:0] raw_seen;
  logic [BTN_COUNT-1:0] stable_level;
  logic [TIME_W-1:0]    change_time [BTN_COUNT];
  btn_event_t           awaited_events [$];
  int                   mismatches = 0;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: event mismatch: %s", $time, msg);
    end
  endtask

  // One poll sample: start button first, then buttons 0 to 15
  task automatic debounce_sample(input logic [BTN_COUNT-1:0] hit,
                                 input logic [TIME_W-1:0] now);
    int                base;
    int                b;
    logic [TIME_W-1:0] elapsed;
    base = awaited_events.size();
    for (int k = 0; k < BTN_COUNT; k++) begin
      b = (k == 0) ? START_INDEX : k - 1;
      elapsed = now - change_time[b];
      if (hit[b] != raw_seen[b]) begin
        // raw change: note level and time only
        raw_seen[b]    = hit[b];
        change_time[b] = now;
      end else if (elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_time} &&
                   stable_level[b] != hit[b]) begin
        stable_level[b] = hit[b];
        awaited_events.push_back('{button: IDX_W'(b), pressed: hit[b], last: 1'b0});
      end
    end
    if (awaited_events.size() > base) begin
      awaited_events[awaited_events.size()-1].last = 1'b1;
    end
  endtask

  // Sample all three ports on the rising edge
  always @(posedge clk) begin
    btn_event_t got;
    btn_event_t want;
    if (!rst_n) begin
      debounce_time = DEBOUNCE_RESET;
      raw_seen      = '0;
      stable_level  = '0;
      for (int k = 0; k < BTN_COUNT; k++) change_time[k] = '0;
      awaited_events.delete();
    end else begin
      if (cfg_wr_en) debounce_time = cfg_wr_data;

      // event side first: its expectation stems from an earlier sample
      if (out_tvalid && out_tready) begin
        got = '{button: out_tdata[IDX_W-1:0], pressed: out_tdata[IDX_W], last: out_tlast};
        if (awaited_events.size() == 0) begin
          flag_mismatch($sformatf("unexpected event: button %0d pressed %0b last %0b",
                                  got.button, got.pressed, got.last));
        end else begin
          want = awaited_events.pop_front();
          if (got.button !== want.button || got.pressed !== want.pressed ||
              got.last !== want.last) begin
            flag_mismatch($sformatf(
              "expected button %0d pressed %0b last %0b, got button %0d pressed %0b last %0b",
              want.button, want.pressed, want.last, got.button, got.pressed, got.last));
          end
        end
      end

      if (in_tvalid && in_tready) begin
        debounce_sample(~in_tdata[START_INDEX:0], in_tdata[TIME_LSB +: TIME_W]);
      end
    end
    mismatch_count <= mismatches;
    events_pending <= awaited_events.size();
  end

endmodule

>>> dv/multi_button_debouncer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debouncer_core_tb
// Drives poll samples into the debouncer under several debounce times, with
// random gaps on the sample side and random stalls on the event side. The
// checker beside the block predicts and compares every event; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module multi_button_debouncer_core_tb;
  import mbd_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 26;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [DEB_W-1:0]      cfg_wr_data = '0;

  int mismatch_count;
  int events_pending;
  int cycle_count = 0;

  // Current pin levels, timestamp and debounce time of the stimulus
  logic [PORT_W-1:0] level_a     = 8'hFF;
  logic [PORT_W-1:0] level_b     = 8'hFF;
  logic              level_start = 1'b1;
  logic [TIME_W-1:0] now_ms      = '0;
  int                debounce_now = 50;

  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;
  int rx_hold   = 0;

  multi_button_debouncer_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  mbd_event_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .events_pending (events_pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Mostly no idling, often a short gap, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hands one poll request to the block; returns at the falling edge after
  // it was taken, with in_tvalid still high
  task automatic poll(input logic [PORT_W-1:0] a, input logic [PORT_W-1:0] b,
                      input logic s, input logic [TIME_W-1:0] t);
    int gap;
    gap = tx_gaps ? idle_length() : 0;
    level_a     = a;
    level_b     = b;
    level_start = s;
    now_ms      = t;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {{(IN_DATA_W-TIME_W-2*PORT_W-1){1'b0}}, t, s, b, a};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off samples until every awaited event is out, then idle for
  // SETTLE_CYCLES so that the pipeline clears
  task automatic drain_events();
    in_tvalid <= 1'b0;
    while (events_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_debounce(input logic [DEB_W-1:0] value);
    drain_events();
    cfg_wr_data  <= value;
    cfg_wr_en    <= 1'b1;
    debounce_now  = int'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly steady pins with sparse bounces; time steps around the debounce
  // time, a few tiny steps and the odd jump anywhere (wrap or backwards)
  task automatic random_poll();
    logic [PORT_W-1:0] a;
    logic [PORT_W-1:0] b;
    logic              s;
    logic [TIME_W-1:0] t;
    int                r;
    a = level_a;
    b = level_b;
    s = level_start;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      a = PORT_W'($urandom_range(0, 255));
      b = PORT_W'($urandom_range(0, 255));
      s = 1'($urandom_range(0, 1));
    end else if (r < 35) begin
      a = a ^ PORT_W'($urandom & $urandom & $urandom);
      b = b ^ PORT_W'($urandom & $urandom & $urandom);
      if ($urandom_range(0, 7) == 0) s = ~s;
    end
    r = $urandom_range(0, 99);
    if (r < 55)      t = now_ms + $urandom_range(0, debounce_now);
    else if (r < 85) t = now_ms + $urandom_range(debounce_now, 2 * debounce_now + 1);
    else if (r < 97) t = now_ms + $urandom_range(0, 3);
    else             t = $urandom;
    poll(a, b, s, t);
  endtask

  // Event receiver
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= 1'b1;
        if (rx_stalls) rx_hold = idle_length();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_button_debouncer_core_tb NOT OK");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int deb_plan [RANDOM_PHASES];
    deb_plan    = '{3, 0, 1000, 65535, 1, 50};
    deb_plan[4] = $urandom_range(2, 65534);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset debounce time of 50 ms
    poll(8'hFF, 8'hFF, 1'b1, 32'd0);            // all released, nothing to do
    poll(8'h00, 8'h00, 1'b0, 32'd10);           // all pressed: raw change only
    poll(8'h00, 8'h00, 1'b0, 32'd59);           // one short of the debounce time
    poll(8'h00, 8'h00, 1'b0, 32'd60);           // every button fires
    poll(8'h55, 8'hAA, 1'b1, 32'd61);           // bounce on half the pins
    poll(8'hFF, 8'hFF, 1'b1, 32'd70);
    poll(8'hFF, 8'hFF, 1'b1, 32'd120);          // every button released
    // timestamp wraps through zero
    poll(8'hFE, 8'hFF, 1'b1, 32'hFFFF_FFF0);
    poll(8'hFE, 8'hFF, 1'b1, 32'h0000_0021);
    poll(8'hFE, 8'hFF, 1'b1, 32'h0000_0022);
    // timestamp going backwards reads as a long wait
    poll(8'hFF, 8'h7F, 1'b1, 32'h0000_1000);
    poll(8'hFF, 8'h7F, 1'b1, 32'h0000_0800);

    // zero debounce: second equal sample is enough, even at the same time
    write_debounce(16'd0);
    poll(8'hF0, 8'h0F, 1'b0, 32'd5000);
    poll(8'hF0, 8'h0F, 1'b0, 32'd5000);

    // longest debounce time
    write_debounce(16'hFFFF);
    poll(8'h0F, 8'hF0, 1'b1, 32'd6000);
    poll(8'h0F, 8'hF0, 1'b1, 32'd6000 + 32'd65534);
    poll(8'h0F, 8'hF0, 1'b1, 32'd6000 + 32'd65535);

    // random phases, each with its own debounce time and idling mix
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_debounce(DEB_W'(deb_plan[phase]));
      tx_gaps   = (phase % 2 == 0);
      rx_stalls = (phase % 3 != 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_poll();
        if ($urandom_range(0, 24) == 0) drain_events();
      end
    end

    drain_events();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("multi_button_debouncer_core_tb OK");
    end else begin
      $display("multi_button_debouncer_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/mbd_pkg.sv
hdl/mbd_front.sv
hdl/mbd_queue.sv
hdl/mbd_back.sv
hdl/multi_button_debouncer_core.sv
dv/mbd_event_checker.sv
dv/multi_button_debouncer_core_tb.sv
